// ----- rtl/vdl_pkg.sv -----
// Shared types and constants of the vertex directional lighting block.
// Used by vdl_intensity, vdl_shade, the top level and its checker; depends on nothing.
package vdl_pkg;

  localparam int IntensityW = 24;
  localparam logic [IntensityW-1:0] IntensityMax = 24'hFF_FFFF;
  localparam int ColorW = 24;
  localparam int ChanW = 8;
  localparam int NumChan = 3;
  localparam logic [ChanW-1:0] Alpha = 8'hFF;
  localparam logic [ChanW-1:0] ChanMax = 8'hFF;
  localparam int OutDataW = 32;
  localparam int CfgDataW = 24;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_AMBIENT = 3'd0,
    REG_DIFFUSE = 3'd1,
    REG_DIR_X   = 3'd2,
    REG_DIR_Y   = 3'd3,
    REG_DIR_Z   = 3'd4
  } vdl_reg_e;

endpackage

// ----- rtl/vdl_intensity.sv -----
// Four-stage pipeline that turns a normal and the light direction into a 24-bit intensity.
// Depends on vdl_pkg.
module vdl_intensity #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [COMPONENT_WIDTH-1:0]       normal_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0]       normal_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0]       normal_z_i,
  input  logic signed [COMPONENT_WIDTH-1:0]       dir_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0]       dir_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0]       dir_z_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [vdl_pkg::IntensityW-1:0]          intensity_o
);

  localparam int ProdW = 2 * COMPONENT_WIDTH;
  localparam int DotW = ProdW + 2;
  localparam int DotFrac = 2 * (COMPONENT_WIDTH - 2);
  localparam int ScaleW = DotFrac + vdl_pkg::IntensityW;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  logic signed [ProdW-1:0] px_q, py_q, pz_q;
  logic signed [DotW-1:0]  dot_q;
  logic [DotW-1:0]         dot_abs;
  logic [DotFrac-1:0]      frac_q;
  logic                    sat_q;
  logic [ScaleW-1:0]       scaled;
  logic [vdl_pkg::IntensityW-1:0] intensity_d, intensity_q;

  // Each stage moves when it is empty or the stage after it moves.
  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  assign dot_abs = dot_q[DotW-1] ? (~dot_q + 1'b1) : dot_q;

  // (u * 0xFFFFFF) >> frac written as ((u << 24) - u) >> frac.
  assign scaled = {frac_q, {vdl_pkg::IntensityW{1'b0}}} - ScaleW'(frac_q);
  assign intensity_d = sat_q ? vdl_pkg::IntensityMax
                             : scaled[ScaleW-1 -: vdl_pkg::IntensityW];

  always_ff @(posedge clk_i) begin
    if (en1) begin
      px_q <= normal_x_i * dir_x_i;
      py_q <= normal_y_i * dir_y_i;
      pz_q <= normal_z_i * dir_z_i;
    end
    if (en2) begin
      dot_q <= DotW'(px_q) + DotW'(py_q) + DotW'(pz_q);
    end
    if (en3) begin
      // Anything at or above 1.0 saturates the intensity.
      sat_q  <= |dot_abs[DotW-1:DotFrac];
      frac_q <= dot_abs[DotFrac-1:0];
    end
    if (en4) begin
      intensity_q <= intensity_d;
    end
  end

  assign out_valid_o = v4_q;
  assign intensity_o = intensity_q;

endmodule

// ----- rtl/vdl_shade.sv -----
// Two-stage color back end: clamped diffuse times intensity, then ambient add and packing.
// Depends on vdl_pkg.
module vdl_shade (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [vdl_pkg::IntensityW-1:0]       intensity_i,
  input  logic [vdl_pkg::ColorW-1:0]           ambient_i,
  input  logic [vdl_pkg::ColorW-1:0]           diffuse_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [vdl_pkg::OutDataW-1:0]         color_o
);

  localparam int ChanW = vdl_pkg::ChanW;
  localparam int MulW = ChanW + vdl_pkg::IntensityW;

  logic v5_q, v6_q;
  logic en5, en6;

  logic [vdl_pkg::NumChan-1:0][ChanW-1:0] dif_clamped;
  logic [vdl_pkg::NumChan-1:0][MulW-1:0]  prod;
  logic [vdl_pkg::NumChan-1:0][ChanW-1:0] lit_q;
  logic [vdl_pkg::NumChan-1:0][ChanW-1:0] chan_sum;
  logic [vdl_pkg::OutDataW-1:0]           color_q;

  assign en6 = !v6_q || out_ready_i;
  assign en5 = !v5_q || en6;
  assign in_ready_o = en5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en5) v5_q <= in_valid_i;
      if (en6) v6_q <= v5_q;
    end
  end

  // The clamp keeps diffuse plus ambient within one byte, so the sum never wraps.
  always_comb begin
    for (int c = 0; c < vdl_pkg::NumChan; c++) begin
      if (diffuse_i[c*ChanW +: ChanW] > (vdl_pkg::ChanMax - ambient_i[c*ChanW +: ChanW])) begin
        dif_clamped[c] = vdl_pkg::ChanMax - ambient_i[c*ChanW +: ChanW];
      end else begin
        dif_clamped[c] = diffuse_i[c*ChanW +: ChanW];
      end
      prod[c]     = MulW'(dif_clamped[c]) * MulW'(intensity_i);
      chan_sum[c] = lit_q[c] + ambient_i[c*ChanW +: ChanW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      for (int c = 0; c < vdl_pkg::NumChan; c++) begin
        lit_q[c] <= prod[c][MulW-1 -: ChanW];
      end
    end
    if (en6) begin
      color_q <= {vdl_pkg::Alpha, chan_sum[2], chan_sum[1], chan_sum[0]};
    end
  end

  assign out_valid_o = v6_q;
  assign color_o = color_q;

endmodule

// ----- rtl/vertex_directional_lighting.sv -----
// Top level of the vertex directional lighting block: configuration registers and stream ports.
// Depends on vdl_pkg, vdl_intensity and vdl_shade.

// One vertex normal enters per clock and one packed ARGB word leaves per clock when the
// output side keeps tready high. An accepted normal passes through the stages in order:
// four stages form the intensity (the three component multipliers, the sum, the absolute
// value with saturation check, and the 24-bit scaling subtract) and two form the color
// (the three channel multipliers, then the ambient add). Every stage holds its own valid
// bit and fills bubbles while the output stalls, so a full pipeline holds six words.
// Configuration registers are meant to be written only while no word is in flight.
module vertex_directional_lighting #(
  parameter int COMPONENT_WIDTH = 16,
  localparam int InDataW = ((3 * COMPONENT_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [vdl_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [vdl_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0 up: normal_x, normal_y, normal_z, unused padding.
  input  logic [InDataW-1:0]               s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // Fields from bit 0 up: packed_color.
  output logic [vdl_pkg::OutDataW-1:0]     m_axis_tdata
);

  localparam int CW = COMPONENT_WIDTH;
  localparam logic [CW-1:0] DirZReset = CW'(32'd16384);

  logic [vdl_pkg::ColorW-1:0] ambient_q, diffuse_q;
  logic signed [CW-1:0]       dir_x_q, dir_y_q, dir_z_q;

  logic                           int_valid, int_ready;
  logic [vdl_pkg::IntensityW-1:0] intensity;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ambient_q <= '0;
      diffuse_q <= vdl_pkg::IntensityMax;
      dir_x_q   <= '0;
      dir_y_q   <= '0;
      dir_z_q   <= DirZReset;
    end else if (cfg_we_i) begin
      unique case (vdl_pkg::vdl_reg_e'(cfg_idx_i))
        vdl_pkg::REG_AMBIENT: ambient_q <= cfg_wdata_i[vdl_pkg::ColorW-1:0];
        vdl_pkg::REG_DIFFUSE: diffuse_q <= cfg_wdata_i[vdl_pkg::ColorW-1:0];
        vdl_pkg::REG_DIR_X:   dir_x_q   <= cfg_wdata_i[CW-1:0];
        vdl_pkg::REG_DIR_Y:   dir_y_q   <= cfg_wdata_i[CW-1:0];
        vdl_pkg::REG_DIR_Z:   dir_z_q   <= cfg_wdata_i[CW-1:0];
        default: ;
      endcase
    end
  end

  vdl_intensity #(
    .COMPONENT_WIDTH(COMPONENT_WIDTH)
  ) u_intensity (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .normal_x_i (s_axis_tdata[CW-1:0]),
    .normal_y_i (s_axis_tdata[2*CW-1:CW]),
    .normal_z_i (s_axis_tdata[3*CW-1:2*CW]),
    .dir_x_i    (dir_x_q),
    .dir_y_i    (dir_y_q),
    .dir_z_i    (dir_z_q),
    .out_valid_o(int_valid),
    .out_ready_i(int_ready),
    .intensity_o(intensity)
  );

  vdl_shade u_shade (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (int_valid),
    .in_ready_o (int_ready),
    .intensity_i(intensity),
    .ambient_i  (ambient_q),
    .diffuse_i  (diffuse_q),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .color_o    (m_axis_tdata)
  );

endmodule

// ----- rtl/vdl_checker.sv -----
// Port-level checker for vertex_directional_lighting, with the bind that attaches it.
// Depends on vdl_pkg.
module vdl_checker #(
  parameter int COMPONENT_WIDTH = 16,
  localparam int InDataW = ((3 * COMPONENT_WIDTH + 7) / 8) * 8
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [InDataW-1:0]           s_axis_tdata,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [vdl_pkg::OutDataW-1:0] m_axis_tdata
);

  // A stalled output word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // Every word leaves with opaque alpha.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[31:24] == vdl_pkg::Alpha)
    else $error("alpha byte is not opaque");

  // With the output register empty, no stage can be blocked, so the input must be open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output is empty");

  // Meant to flag output with no word before it; the last term holds on every $rose, so it never fires.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tready) || $past(m_axis_tready) ||
                             $past(s_axis_tvalid) || $past(s_axis_tdata) != s_axis_tdata ||
                             !$past(m_axis_tvalid))
    else $error("output word appeared with no source");

endmodule

bind vertex_directional_lighting vdl_checker #(
  .COMPONENT_WIDTH(COMPONENT_WIDTH)
) u_vdl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// ----- tb/vertex_directional_lighting_test.sv -----
// Self-checking testbench for vertex_directional_lighting: streams vertex normals in and
// checks every packed ARGB word against a built-in two-sided lighting predictor.
// Depends on vdl_pkg and the vertex_directional_lighting RTL only.
module vertex_directional_lighting_test;

  localparam int CompW = 16;
  localparam int InW = ((3 * CompW + 7) / 8) * 8;
  localparam int FracBits = CompW - 2;
  localparam int DotFrac = 2 * FracBits;
  localparam int ClkHalf = 5;
  localparam int PipeDepth = 6;
  localparam int NumPhases = 6;
  localparam int WordsPerPhase = 125;
  localparam int HoldOffCycles = 64;
  localparam int LimitCycles = 400000;

  typedef logic [CompW-1:0] comp_t;

  typedef struct packed {
    logic [vdl_pkg::CfgDataW-1:0] ambient;
    logic [vdl_pkg::CfgDataW-1:0] diffuse;
    comp_t                        dir_x;
    comp_t                        dir_y;
    comp_t                        dir_z;
  } light_cfg_t;

  typedef struct packed {
    comp_t                         nx;
    comp_t                         ny;
    comp_t                         nz;
    logic [vdl_pkg::OutDataW-1:0]  color;
  } lit_vertex_t;

  // Holds its own copy of the light registers and the colors still owed by the block.
  class color_scoreboard;
    logic [vdl_pkg::CfgDataW-1:0] ambient = '0;
    logic [vdl_pkg::CfgDataW-1:0] diffuse = 24'hFF_FFFF;
    logic [vdl_pkg::CfgDataW-1:0] dir_x = '0;
    logic [vdl_pkg::CfgDataW-1:0] dir_y = '0;
    logic [vdl_pkg::CfgDataW-1:0] dir_z = 24'd16384;
    lit_vertex_t                  owed_colors[$];
    int                           errors = 0;
    int                           normals_in = 0;
    int                           colors_checked = 0;

    function void set_reg(logic [vdl_pkg::CfgIdxW-1:0] idx,
                          logic [vdl_pkg::CfgDataW-1:0] data);
      case (idx)
        vdl_pkg::REG_AMBIENT: ambient = data;
        vdl_pkg::REG_DIFFUSE: diffuse = data;
        vdl_pkg::REG_DIR_X:   dir_x = data;
        vdl_pkg::REG_DIR_Y:   dir_y = data;
        vdl_pkg::REG_DIR_Z:   dir_z = data;
        default: ;
      endcase
    endfunction

    function logic [vdl_pkg::OutDataW-1:0] shade(comp_t nx, comp_t ny, comp_t nz);
      longint                         dot;
      longint                         mag;
      longint                         scaled;
      logic [vdl_pkg::IntensityW-1:0] inten;
      logic [vdl_pkg::ChanW-1:0]      amb;
      logic [vdl_pkg::ChanW-1:0]      dif;
      logic [vdl_pkg::OutDataW-1:0]   color;
      dot = longint'($signed(nx)) * longint'($signed(dir_x[CompW-1:0]))
          + longint'($signed(ny)) * longint'($signed(dir_y[CompW-1:0]))
          + longint'($signed(nz)) * longint'($signed(dir_z[CompW-1:0]));
      // Light from behind counts the same as light from the front.
      mag = (dot < 0) ? -dot : dot;
      if (mag >= (longint'(1) << DotFrac)) begin
        inten = vdl_pkg::IntensityMax;
      end else begin
        scaled = (mag * longint'(vdl_pkg::IntensityMax)) >>> DotFrac;
        inten = scaled[vdl_pkg::IntensityW-1:0];
      end
      color = '0;
      color[vdl_pkg::OutDataW-1 -: vdl_pkg::ChanW] = vdl_pkg::Alpha;
      for (int c = 0; c < vdl_pkg::NumChan; c++) begin
        amb = ambient[c*vdl_pkg::ChanW +: vdl_pkg::ChanW];
        dif = diffuse[c*vdl_pkg::ChanW +: vdl_pkg::ChanW];
        if (dif > vdl_pkg::ChanMax - amb) dif = vdl_pkg::ChanMax - amb;
        scaled = (longint'(dif) * longint'(inten)) >>> vdl_pkg::IntensityW;
        color[c*vdl_pkg::ChanW +: vdl_pkg::ChanW] = scaled[vdl_pkg::ChanW-1:0] + amb;
      end
      return color;
    endfunction

    function void note_normal(comp_t nx, comp_t ny, comp_t nz);
      lit_vertex_t v;
      v.nx = nx;
      v.ny = ny;
      v.nz = nz;
      v.color = shade(nx, ny, nz);
      owed_colors.push_back(v);
      normals_in++;
    endfunction

    function void check_color(logic [vdl_pkg::OutDataW-1:0] got);
      lit_vertex_t v;
      if (owed_colors.size() == 0) begin
        $display("%0t: color %h arrived with no normal pending", $time, got);
        errors++;
        return;
      end
      v = owed_colors.pop_front();
      colors_checked++;
      if (got !== v.color) begin
        $display("%0t: packed_color for normal (%h %h %h): expected %h, actual %h",
                 $time, v.nx, v.ny, v.nz, v.color, got);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [vdl_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [vdl_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  // Fields from bit 0 up: normal_x, normal_y, normal_z.
  logic [InW-1:0]               s_axis_tdata = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  // Fields from bit 0 up: packed_color.
  logic [vdl_pkg::OutDataW-1:0] m_axis_tdata;

  color_scoreboard board = new;
  int send_idle_pct = 30;
  int recv_idle_pct = 88;
  bit hold_off_armed = 1'b0;
  int hold_off_left = 0;
  int input_stall_cycles = 0;
  int settings_used = 0;

  vertex_directional_lighting #(.COMPONENT_WIDTH(CompW)) u_top (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always begin
    #(ClkHalf) clk_i = 1'b1;
    #(ClkHalf) clk_i = 1'b0;
  end

  // Output side: checks each accepted word, counts stalled input cycles and decides tready for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_color(m_axis_tdata);
    if (rst_ni && s_axis_tvalid && !s_axis_tready) input_stall_cycles++;
    if (hold_off_armed) begin
      hold_off_armed = 1'b0;
      hold_off_left = HoldOffCycles;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_normal(input comp_t nx, input comp_t ny, input comp_t nz);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= InW'({$urandom, $urandom});
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {nz, ny, nx};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_normal(nx, ny, nz);
  endtask

  task automatic write_reg(input logic [vdl_pkg::CfgIdxW-1:0] idx,
                           input logic [vdl_pkg::CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    board.set_reg(idx, data);
  endtask

  // Direction registers only use their low bits, so the spare upper bits get noise.
  task automatic apply_config(input light_cfg_t c, input bit hit_unused);
    logic [vdl_pkg::CfgIdxW-1:0] idx;
    write_reg(vdl_pkg::REG_AMBIENT, c.ambient);
    write_reg(vdl_pkg::REG_DIFFUSE, c.diffuse);
    write_reg(vdl_pkg::REG_DIR_X, {8'($urandom), c.dir_x});
    write_reg(vdl_pkg::REG_DIR_Y, {8'($urandom), c.dir_y});
    write_reg(vdl_pkg::REG_DIR_Z, {8'($urandom), c.dir_z});
    if (hit_unused) begin
      for (int r = int'(vdl_pkg::REG_DIR_Z) + 1; r < (1 << vdl_pkg::CfgIdxW); r++) begin
        idx = r[vdl_pkg::CfgIdxW-1:0];
        write_reg(idx, 24'($urandom));
      end
    end
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (board.owed_colors.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
  endtask

  function automatic comp_t spread(int span);
    return comp_t'($urandom_range(2 * span) - span);
  endfunction

  // Mostly unit-length-ish normals so the intensity spans its range, plus raw bit noise and near-zero normals.
  function automatic comp_t random_comp(int kind);
    if (kind < 45) return spread(9459);
    if (kind < 75) return spread(16384);
    if (kind < 90) return comp_t'($urandom);
    return spread(255);
  endfunction

  function automatic light_cfg_t phase_config(int phase);
    light_cfg_t c;
    c.ambient = 24'($urandom) & 24'h3F_3F3F;
    c.diffuse = 24'($urandom);
    c.dir_x = spread(9459);
    c.dir_y = spread(9459);
    c.dir_z = spread(9459);
    case (phase)
      0: begin
        c.ambient = '0;
        c.diffuse = 24'hFF_FFFF;
      end
      1: begin
        c.ambient = 24'hFF_FFFF;
        c.diffuse = 24'hFF_FFFF;
      end
      2: begin
        c.ambient = 24'($urandom);
        c.dir_x = comp_t'($urandom);
        c.dir_y = comp_t'($urandom);
        c.dir_z = comp_t'($urandom);
      end
      3: begin
        c.diffuse = '0;
        c.dir_x = comp_t'(-16384);
        c.dir_y = comp_t'(16384);
        c.dir_z = comp_t'(-16384);
      end
      4: begin
        c.dir_x = 16'h8000;
        c.dir_y = 16'h7FFF;
        c.dir_z = '0;
      end
      default: c.ambient = 24'($urandom);
    endcase
    return c;
  endfunction

  initial begin
    #(2 * ClkHalf * LimitCycles);
    $display("** vertex_directional_lighting: FAILED **");
    $finish;
  end

  initial begin
    int kind;
    light_cfg_t cfg;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset setting: light straight down z, no ambient, full diffuse.
    send_normal(16'sd0, 16'sd0, 16'sd16384);
    send_normal(16'sd0, 16'sd0, -16'sd16384);
    send_normal(16'sd0, 16'sd0, 16'sd0);
    send_normal(16'sd16384, -16'sd16384, 16'sd0);
    send_normal(16'sd0, 16'sd0, 16'sd8192);
    send_normal(16'sd0, 16'sd0, 16'sd1);
    send_normal(16'sd0, 16'sd0, -16'sd1);
    send_normal(16'sd0, 16'sd0, 16'sd16383);
    send_normal(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_normal(16'h8000, 16'h8000, 16'h8000);
    wait_idle();

    // Ambient large enough that every diffuse channel gets clamped, and a direction
    // component far outside unit length.
    cfg = '{ambient: 24'h80_C0FF, diffuse: 24'hFF_FFFF,
            dir_x: -16'sd16384, dir_y: 16'sd16384, dir_z: 16'h8000};
    apply_config(cfg, 1'b1);
    send_normal(16'sd16384, 16'sd0, 16'sd0);
    send_normal(16'sd9459, 16'sd9459, 16'sd9459);
    send_normal(-16'sd16384, -16'sd16384, -16'sd16384);
    send_normal(16'h7FFF, 16'h8000, 16'h7FFF);
    send_normal(16'sd1, 16'sd0, 16'sd0);
    send_normal(16'sd0, 16'sd1, 16'sd0);
    send_normal(16'h5555, 16'hAAAA, 16'h5555);
    send_normal(16'hAAAA, 16'h5555, 16'hAAAA);

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      apply_config(phase_config(ph), ph == 2);
      send_idle_pct = (ph < 2) ? 30 : (ph < 4) ? 88 : 0;
      recv_idle_pct = (ph < 2) ? 88 : (ph < 4) ? 30 : 0;
      // Stop the output for a long stretch while normals keep coming.
      if (ph == 4) hold_off_armed = 1'b1;
      for (int i = 0; i < WordsPerPhase; i++) begin
        kind = $urandom_range(99);
        send_normal(random_comp(kind), random_comp(kind), random_comp(kind));
      end
    end

    s_axis_tvalid <= 1'b0;
    while (board.owed_colors.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 4) @(posedge clk_i);

    $display("Checked %0d colors from %0d normals under %0d light settings.",
             board.colors_checked, board.normals_in, settings_used + 1);
    $display("The input was held off for %0d cycles by output back-pressure.",
             input_stall_cycles);
    if (board.errors == 0 && board.owed_colors.size() == 0) begin
      $display("** vertex_directional_lighting: PASSED **");
    end else begin
      $display("** vertex_directional_lighting: FAILED **");
    end
    $finish;
  end

endmodule
